// File: rtl/core/tlcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcd_pkg
// shared constants, request codes and helpers for the text lcd write engine
// ----------------------------------------------------------------------------
package tlcd_pkg;

	localparam int unsigned CellCount = 64;
	localparam int unsigned RowCells  = 16;
	localparam int unsigned AddrW     = $clog2(CellCount);

	localparam logic [7:0] SyncCmd  = 8'hF8;
	localparam logic [7:0] SyncData = 8'hFA;
	localparam logic [7:0] HighMask = 8'hF0;
	localparam logic [7:0] Space    = 8'h20;

	// triplet index of the final triplet for char writes and row refreshes
	localparam logic [4:0] LastTripPair = 5'd2;
	localparam logic [4:0] LastTripRow  = 5'd16;

	typedef enum logic [1:0] {
		KIND_WRITE_SEND = 2'd0,
		KIND_STORE      = 2'd1,
		KIND_REFRESH    = 2'd2,
		KIND_UNUSED     = 2'd3
	} kind_t;

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		unique case (r)
			2'd0: b = 8'h80;
			2'd1: b = 8'h90;
			2'd2: b = 8'h88;
			2'd3: b = 8'h98;
			default: b = 8'h80;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/core/text_lcd_serial_write_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_lcd_serial_write_engine_unit
// 4x16 text buffer with serial byte stream generation for a text lcd
// ----------------------------------------------------------------------------
// A request is taken when the engine is not streaming. A store-only request
// produces no output. A char write streams 9 bytes and a row refresh 51
// bytes, one byte per cycle while out_ready is high; no new request is taken
// until the last byte of the current one has been generated. The text
// buffer is a 64 x 8 memory with one registered read port; cells never
// written since reset read as spaces through a per-cell valid flag, so no
// clearing pass is needed. The next cell is read while the current triplet
// is still going out, which hides the read latency.
module text_lcd_serial_write_engine_unit
	import tlcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [3:0] column,
	input  logic [1:0] row,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tx_byte,
	output logic       last
);

	logic [7:0]       mem_q [CellCount];
	logic [CellCount-1:0] cell_valid_q;
	logic [7:0]       rd_data_q;
	logic             rd_valid_q;

	logic             busy_q;
	logic             row_mode_q;
	logic [4:0]       trip_q;
	logic [1:0]       phase_q;
	logic [7:0]       cur_byte_q;
	logic [AddrW-1:0] cell_q;

	logic             out_valid_q;
	logic [7:0]       tx_byte_q;
	logic             last_q;

	logic             accept;
	logic             advance;
	logic             do_write;
	logic [AddrW-1:0] wr_addr;
	logic [7:0]       emit_byte;
	logic             emit_last;
	logic [7:0]       cell_byte;

	assign in_ready  = ~busy_q;
	assign accept    = in_valid & in_ready;
	assign advance   = busy_q & (~out_valid_q | out_ready);
	assign wr_addr   = {row, column};
	assign do_write  = accept & ((kind == KIND_WRITE_SEND) | (kind == KIND_STORE));
	assign cell_byte = rd_valid_q ? rd_data_q : Space;

	always_comb begin
		case (phase_q)
			2'd0:    emit_byte = (trip_q == 5'd0) ? SyncCmd : SyncData;
			2'd1:    emit_byte = cur_byte_q & HighMask;
			default: emit_byte = {cur_byte_q[3:0], 4'h0};
		endcase
		emit_last = (phase_q == 2'd2) &&
			(trip_q == (row_mode_q ? LastTripRow : LastTripPair));
	end

	// text buffer memory, written on accept of a char write or store and read every cycle at cell_q
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_q[wr_addr] <= char_code;
		end
		rd_data_q <= mem_q[cell_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q <= '0;
			rd_valid_q   <= 1'b0;
		end else begin
			if (do_write) begin
				cell_valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= cell_valid_q[cell_q];
		end
	end

	// sequencer: triplet counter and byte phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			row_mode_q <= 1'b0;
			trip_q     <= '0;
			phase_q    <= '0;
			cur_byte_q <= '0;
			cell_q     <= '0;
		end else if (accept) begin
			trip_q  <= '0;
			phase_q <= '0;
			case (kind)
				KIND_WRITE_SEND: begin
					busy_q     <= 1'b1;
					row_mode_q <= 1'b0;
					cur_byte_q <= row_base(row) + {5'd0, column[3:1]};
					cell_q     <= {row, column[3:1], 1'b0};
				end
				KIND_REFRESH: begin
					busy_q     <= 1'b1;
					row_mode_q <= 1'b1;
					cur_byte_q <= row_base(row);
					cell_q     <= {row, 4'd0};
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end else if (advance) begin
			if (phase_q == 2'd2) begin
				if (emit_last) begin
					busy_q <= 1'b0;
				end else begin
					trip_q     <= trip_q + 5'd1;
					phase_q    <= '0;
					cur_byte_q <= cell_byte;
					cell_q     <= cell_q + AddrW'(1);
				end
			end else begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_byte_q <= emit_byte;
			last_q    <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign last      = last_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for text_lcd_serial_write_engine_unit: keeps its own
// 4x16 text buffer, predicts every link byte of each request and compares it
// with the output stream while both handshakes idle and stall at random
// ----------------------------------------------------------------------------
module tb
	import tlcd_pkg::*;
;

	localparam int unsigned LongHold    = 400;
	localparam int unsigned DrainCycles = 64;
	localparam int unsigned CycleLimit  = 500000;
	localparam int unsigned RandomReqs  = 440;

	typedef enum logic [1:0] {
		RX_STREAM,
		RX_COIN,
		RX_SPARSE,
		RX_STRIDE
	} rx_mode_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
	} link_byte_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] kind;
	logic [3:0] column;
	logic [1:0] row;
	logic [7:0] char_code;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] tx_byte;
	logic       last;

	text_lcd_serial_write_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.column    (column),
		.row       (row),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.last      (last)
	);

	// model of the display text buffer, row-major
	logic [7:0] text_cells [CellCount];
	logic [7:0] row_addr_base [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

	link_byte_t  link_bytes_due [$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned burst_left;
	int unsigned holds_asked;
	int unsigned holds_granted;
	int unsigned hold_left;
	int unsigned rx_mode_left;
	rx_mode_t    rx_mode;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("%0t: timeout with %0d link bytes outstanding", $time,
				link_bytes_due.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	// receiver: changes its stall pattern every so often, long hold on demand
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (holds_granted < holds_asked) begin
			holds_granted++;
			hold_left = LongHold;
			out_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(20, 150);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				RX_STREAM: out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= (cycle_count % 3 != 0);
			endcase
		end
	end

	// compare each accepted link byte with the oldest prediction
	always @(posedge clk) begin
		link_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (link_bytes_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected byte, expected none, got tx_byte=%02h last=%0b",
					$time, tx_byte, last);
			end else begin
				want = link_bytes_due.pop_front();
				if (tx_byte !== want.tx_byte) begin
					mismatch_count++;
					$display("%0t: tx_byte mismatch, expected %02h, got %02h",
						$time, want.tx_byte, tx_byte);
				end
				if (last !== want.last) begin
					mismatch_count++;
					$display("%0t: last mismatch, expected %0b, got %0b",
						$time, want.last, last);
				end
			end
		end
	end

	// sync byte, high nibble, low nibble shifted up
	task automatic queue_triplet(input logic [7:0] sync, input logic [7:0] b,
			input logic fin);
		link_bytes_due.push_back('{tx_byte: sync, last: 1'b0});
		link_bytes_due.push_back('{tx_byte: b & HighMask, last: 1'b0});
		link_bytes_due.push_back('{tx_byte: {b[3:0], 4'h0}, last: fin});
	endtask

	task automatic predict_link_bytes(input kind_t k, input logic [3:0] col,
			input logic [1:0] r, input logic [7:0] ch);
		logic [5:0] pair_cell;
		case (k)
			KIND_WRITE_SEND: begin
				text_cells[{r, col}] = ch;
				pair_cell = {r, col[3:1], 1'b0};
				queue_triplet(SyncCmd, row_addr_base[r] + {5'd0, col[3:1]}, 1'b0);
				queue_triplet(SyncData, text_cells[pair_cell], 1'b0);
				queue_triplet(SyncData, text_cells[pair_cell | 6'd1], 1'b1);
			end
			KIND_STORE: text_cells[{r, col}] = ch;
			KIND_REFRESH: begin
				queue_triplet(SyncCmd, row_addr_base[r], 1'b0);
				for (int i = 0; i < RowCells; i++)
					queue_triplet(SyncData, text_cells[{r, 4'(i)}], i == RowCells - 1);
			end
			default: ;
		endcase
	endtask

	// offer one request, bursts of random length separated by random gaps
	task automatic send_request(input kind_t k, input logic [3:0] col,
			input logic [1:0] r, input logic [7:0] ch);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 8);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		column    <= col;
		row       <= r;
		char_code <= ch;
		do
			@(posedge clk);
		while (!in_ready);
		predict_link_bytes(k, col, r, ch);
	endtask

	task automatic test_blank_rows;
		for (int r = 0; r < 4; r++)
			send_request(KIND_REFRESH, 4'd0, 2'(r), 8'h00);
	endtask

	task automatic test_char_pairs;
		send_request(KIND_WRITE_SEND, 4'd0, 2'd0, 8'h00);
		send_request(KIND_WRITE_SEND, 4'd15, 2'd3, 8'hFF);
		send_request(KIND_WRITE_SEND, 4'd1, 2'd1, 8'hA5);
		send_request(KIND_WRITE_SEND, 4'd14, 2'd2, 8'h5A);
		send_request(KIND_WRITE_SEND, 4'd1, 2'd0, 8'h81);
	endtask

	task automatic test_store_only;
		send_request(KIND_STORE, 4'd7, 2'd2, 8'h3C);
		send_request(KIND_STORE, 4'd0, 2'd3, 8'hC3);
		// even neighbor write must carry the stored odd cell along
		send_request(KIND_WRITE_SEND, 4'd6, 2'd2, 8'h7E);
		send_request(KIND_REFRESH, 4'd9, 2'd3, 8'hFF);
	endtask

	task automatic test_unused_kind;
		send_request(KIND_UNUSED, 4'd15, 2'd3, 8'hEE);
		send_request(KIND_UNUSED, 4'd0, 2'd0, 8'h11);
		send_request(KIND_REFRESH, 4'd0, 2'd0, 8'h00);
		send_request(KIND_REFRESH, 4'd0, 2'd2, 8'h00);
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_backpressure;
		holds_asked++;
		for (int i = 0; i < 12; i++)
			send_request((i % 3 == 0) ? KIND_WRITE_SEND : KIND_REFRESH,
				4'($urandom), 2'($urandom), 8'($urandom));
	endtask

	task automatic test_random_traffic;
		int unsigned useful;
		int unsigned pick;
		int unsigned n;
		logic [1:0]  r;
		logic [3:0]  col;
		kind_t       k;
		useful = 0;
		while (useful < RandomReqs) begin
			pick = $urandom_range(0, 99);
			r = 2'($urandom);
			if (pick < 60) begin
				// edit a row, then refresh it half the time
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					k = ($urandom_range(0, 2) == 0) ? KIND_WRITE_SEND : KIND_STORE;
					send_request(k, 4'($urandom), r, 8'($urandom));
					useful++;
				end
				if ($urandom_range(0, 1) == 0) begin
					send_request(KIND_REFRESH, 4'($urandom), r, 8'($urandom));
					useful++;
				end
			end else if (pick < 85) begin
				k = kind_t'($urandom_range(0, 3));
				send_request(k, 4'($urandom), r, 8'($urandom));
				if (k != KIND_UNUSED)
					useful++;
			end else begin
				// both halves of one pair back to back
				col = 4'($urandom);
				send_request(KIND_WRITE_SEND, col, r, 8'($urandom));
				send_request(KIND_WRITE_SEND, col ^ 4'd1, r, 8'($urandom));
				useful += 2;
			end
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		kind          <= KIND_WRITE_SEND;
		column        <= '0;
		row           <= '0;
		char_code     <= '0;
		out_ready     <= 1'b0;
		mismatch_count = 0;
		cycle_count    = 0;
		burst_left     = 0;
		holds_asked    = 0;
		holds_granted  = 0;
		hold_left      = 0;
		rx_mode_left   = 0;
		rx_mode        = RX_STREAM;
		foreach (text_cells[i])
			text_cells[i] = Space;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_blank_rows();
		test_char_pairs();
		test_store_only();
		test_unused_kind();
		test_backpressure();
		test_random_traffic();

		in_valid <= 1'b0;
		while (link_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (link_bytes_due.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/tlcd_pkg.sv
rtl/core/text_lcd_serial_write_engine_unit.sv
tb/tb.sv
